// ===== sv/tsr_pkg.sv =====
// Package: shared types and constants for the TCP segment reorder unit.
`default_nettype none
package tsr_pkg;
    localparam int unsigned TableDepthDefault = 16;
    localparam logic [31:0] AgeLimitReset = 32'd30000;
    localparam int unsigned InDataW = 160;
    localparam int unsigned OutDataW = 64;

    localparam logic FuncArrival = 1'b0;
    localparam logic FuncRestart = 1'b1;
    localparam logic StatusDelivered = 1'b0;
    localparam logic StatusRejected = 1'b1;
    localparam logic [1:0] RegAgeLimit = 2'd0;

    typedef struct packed {
        logic        func;
        logic [31:0] seq_num;
        logic [15:0] seg_len;
        logic        syn_flag;
        logic [47:0] arrival_ms;
        logic [47:0] now_ms;
        logic [7:0]  seg_handle;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  out_handle;
        logic [31:0] out_seq;
        logic [15:0] out_len;
        logic        last;
    } res_t;
endpackage
`default_nettype wire

// ===== sv/tcp_segment_reorder_unit.sv =====
// Top level: TCP segment reorder unit with APB configuration.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tuser=func, tdata=segment fields
// m_axis  | out | m_axis_tvalid/tready   | tuser=status, tlast=last, tdata
// apb     | in  | psel/penable/pready    | age_limit_ms at address 0
//
// An arrival runs repeated scan passes over the table until a pass matches
// no entry; each pass walks the table one entry a cycle, except while a
// delivery waits for the output register.
// Reset clears table fill and expected sequence.
// A stalled output holds the scan at the next delivery; two commands queue.
`default_nettype none
module tcp_segment_reorder_unit
#(
    parameter int unsigned TABLE_DEPTH = tsr_pkg::TableDepthDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] seq_num, [47:32] seg_len, [48] syn_flag, [96:49] arrival_ms,
    // [144:97] now_ms, [152:145] seg_handle, zero fill
    input  wire logic [159:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_handle, [39:8] out_seq, [55:40] out_len, zero fill
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tuser,   // [0] status
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tsr_pkg::*;

    cmd_t        in_cmd;
    cmd_t        q_cmd;
    res_t        res;
    logic        q_valid;
    logic        q_ready;
    logic [31:0] age_limit_reg;

    assign in_cmd = '{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32],
                      s_axis_tdata[48], s_axis_tdata[96:49], s_axis_tdata[144:97],
                      s_axis_tdata[152:145]};

    assign pready = 1'b1;
    assign prdata = (paddr == RegAgeLimit) ? age_limit_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AgeLimitReset;
        end
        else if (psel && penable && pwrite && paddr == RegAgeLimit)
        begin
            age_limit_reg <= pwdata;
        end
    end

    tsr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    tsr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .age_limit (age_limit_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {8'd0, res.out_len, res.out_seq, res.out_handle};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

// ===== sv/tsr_front.sv =====
// Front end: accepts stream transfers into a two-entry command queue.
`default_nettype none
module tsr_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tsr_pkg::cmd_t         in_cmd,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output tsr_pkg::cmd_t              q_cmd
);
    import tsr_pkg::*;

    cmd_t       buf_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;

    logic push;
    logic pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !in_ready)
        else $error("queue full but ready");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 && !push) |=> (count_reg == 2'd0))
        else $error("queue filled without a transfer");
endmodule
`default_nettype wire

// ===== sv/tsr_back.sv =====
// Back end: pending table, repeated scan passes and result register.
`default_nettype none
module tsr_back
#(
    parameter int unsigned TABLE_DEPTH = tsr_pkg::TableDepthDefault
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire tsr_pkg::cmd_t  q_cmd,
    input  wire logic [31:0]    age_limit,
    output logic                res_valid,
    input  wire logic           res_ready,
    output tsr_pkg::res_t       res
);
    import tsr_pkg::*;

    localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_REJ, ST_SCAN, ST_EMIT, ST_TAIL} state_t;

    state_t          state_reg;
    logic [CntW-1:0] n_reg;      // entries in table
    logic [CntW-1:0] i_reg;      // read index
    logic [CntW-1:0] w_reg;      // write index
    logic            moved_reg;
    logic [31:0]     exp_reg;
    logic            emitted_reg;
    logic            old_thr_ok_reg;
    logic [47:0]     old_thr_reg;
    res_t            pend_reg;    // held result, delivered or rejected, waiting to be pushed
    logic            res_valid_reg;
    res_t            res_reg;

    logic [31:0] e_seq [TABLE_DEPTH];
    logic [15:0] e_len [TABLE_DEPTH];
    logic        e_syn [TABLE_DEPTH];
    logic [47:0] e_time [TABLE_DEPTH];
    logic [7:0]  e_id [TABLE_DEPTH];

    logic [IdxW-1:0] ri;
    logic [IdxW-1:0] wi;
    logic [31:0]     exp_eff;
    logic            drop;
    logic            match;
    logic            keep;
    logic            out_free;
    logic            scan_hold;

    assign ri       = i_reg[IdxW-1:0];
    assign wi       = w_reg[IdxW-1:0];
    assign out_free = !res_valid_reg || res_ready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a delivery that must push the held result waits for the output register
    assign scan_hold = match && (e_len[ri] != 16'd0) && emitted_reg && !out_free;

    always_comb
    begin
        exp_eff = (exp_reg == 32'd0) ? e_seq[ri] : exp_reg;
        match   = 1'b0;
        drop    = 1'b0;
        if (exp_reg == 32'd0 && e_syn[ri])
        begin
            drop = 1'b1;
        end
        else if (exp_eff == e_seq[ri])
        begin
            match = 1'b1;
            drop  = 1'b1;
        end
        else if (old_thr_ok_reg && (e_time[ri] < old_thr_reg))
        begin
            drop = 1'b1;
        end
        keep = !drop;
    end

    // table storage; compaction copies entry i down to w
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready && q_cmd.func == FuncArrival
            && n_reg < CntW'(TABLE_DEPTH))
        begin
            e_seq[n_reg[IdxW-1:0]]  <= q_cmd.seq_num;
            e_len[n_reg[IdxW-1:0]]  <= q_cmd.seg_len;
            e_syn[n_reg[IdxW-1:0]]  <= q_cmd.syn_flag;
            e_time[n_reg[IdxW-1:0]] <= q_cmd.arrival_ms;
            e_id[n_reg[IdxW-1:0]]   <= q_cmd.seg_handle;
        end
        else if (state_reg == ST_SCAN && i_reg < n_reg && keep && !scan_hold)
        begin
            e_seq[wi]  <= e_seq[ri];
            e_len[wi]  <= e_len[ri];
            e_syn[wi]  <= e_syn[ri];
            e_time[wi] <= e_time[ri];
            e_id[wi]   <= e_id[ri];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            moved_reg      <= 1'b0;
            exp_reg        <= '0;
            emitted_reg    <= 1'b0;
            old_thr_ok_reg <= 1'b0;
            old_thr_reg    <= '0;
            pend_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        old_thr_ok_reg <= (q_cmd.now_ms > {16'd0, age_limit});
                        old_thr_reg    <= q_cmd.now_ms - {16'd0, age_limit};
                        emitted_reg    <= 1'b0;
                        i_reg          <= '0;
                        w_reg          <= '0;
                        moved_reg      <= 1'b0;
                        if (q_cmd.func == FuncRestart)
                        begin
                            exp_reg <= '0;
                            n_reg   <= '0;
                        end
                        else if (n_reg >= CntW'(TABLE_DEPTH))
                        begin
                            pend_reg <= '{StatusRejected, q_cmd.seg_handle,
                                          q_cmd.seq_num, q_cmd.seg_len, 1'b0};
                            state_reg <= ST_REJ;
                        end
                        else
                        begin
                            n_reg     <= n_reg + CntW'(1);
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_REJ:
                begin
                    // held back so that last can be set on the final result
                    emitted_reg <= 1'b1;
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (i_reg < n_reg)
                    begin
                        if (!scan_hold)
                        begin
                            if (exp_reg == 32'd0 && !e_syn[ri])
                            begin
                                exp_reg <= e_seq[ri];
                            end
                            if (match)
                            begin
                                exp_reg   <= exp_eff + {16'd0, e_len[ri]};
                                moved_reg <= 1'b1;
                            end
                            if (keep)
                            begin
                                w_reg <= w_reg + CntW'(1);
                            end
                            i_reg <= i_reg + CntW'(1);
                            if (match && e_len[ri] != 16'd0)
                            begin
                                // push previous pending result, hold this one
                                if (emitted_reg)
                                begin
                                    state_reg <= ST_EMIT;
                                end
                                pend_reg <= '{StatusDelivered, e_id[ri], e_seq[ri],
                                              e_len[ri], 1'b0};
                                emitted_reg <= 1'b1;
                                if (emitted_reg)
                                begin
                                    res_reg <= pend_reg;
                                end
                            end
                        end
                    end
                    else
                    begin
                        n_reg <= w_reg;
                        i_reg <= '0;
                        w_reg <= '0;
                        moved_reg <= 1'b0;
                        if (!moved_reg)
                        begin
                            state_reg <= ST_TAIL;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_TAIL:
                begin
                    if (!emitted_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        res_reg       <= '{pend_reg.status, pend_reg.out_handle,
                                           pend_reg.out_seq, pend_reg.out_len, 1'b1};
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CntW'(TABLE_DEPTH))
        else $error("fill count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (w_reg <= i_reg))
        else $error("compaction write index passed read index");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg)
        else $error("result lost while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> (state_reg == ST_IDLE))
        else $error("command taken mid scan");
endmodule
`default_nettype wire

// ===== tb/tcp_segment_reorder_unit_tb.sv =====
// Testbench for the TCP segment reorder unit: directed and random segment streams, checked live.
`timescale 1ns / 100ps
module tcp_segment_reorder_unit_tb;
    import tsr_pkg::*;

    localparam int Depth = 16;
    localparam int DrainCycles = 1200;

    typedef struct {
        logic        status;
        logic [7:0]  handle;
        logic [31:0] seq;
        logic [15:0] len;
        logic        last;
    } seg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // shadow of the reorder state
    logic [31:0] age_lim;
    logic [31:0] next_seq;
    logic        ent_valid [Depth];
    logic [31:0] ent_seq [Depth];
    logic [15:0] ent_len [Depth];
    logic        ent_syn [Depth];
    logic [47:0] ent_time [Depth];
    logic [7:0]  ent_id [Depth];

    seg_result_t pending_q[$];
    int errors = 0;
    bit quiet = 1'b0;

    tcp_segment_reorder_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic reorder_step(input logic func, input logic [31:0] seq,
                                input logic [15:0] len, input logic syn,
                                input logic [47:0] arr, input logic [47:0] now,
                                input logic [7:0] id);
        seg_result_t r;
        seg_result_t outs[$];
        int n;
        int w;
        bit moved;
        bit drop;
        if (func == FuncRestart)
        begin
            next_seq = '0;
            for (int i = 0; i < Depth; i++) ent_valid[i] = 1'b0;
            return;
        end
        n = 0;
        while (n < Depth && ent_valid[n]) n++;
        if (n >= Depth)
        begin
            r = '{StatusRejected, id, seq, len, 1'b0};
            outs.insert(outs.size(), r);
        end
        else
        begin
            ent_valid[n] = 1'b1; ent_seq[n] = seq; ent_len[n] = len;
            ent_syn[n] = syn; ent_time[n] = arr; ent_id[n] = id;
        end
        do
        begin
            n = 0;
            while (n < Depth && ent_valid[n]) n++;
            w = 0;
            moved = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                drop = 1'b0;
                if (next_seq == 0)
                begin
                    if (ent_syn[i]) drop = 1'b1;
                    else next_seq = ent_seq[i];
                end
                if (!drop)
                begin
                    if (next_seq == ent_seq[i])
                    begin
                        next_seq = next_seq + 32'(ent_len[i]);
                        if (ent_len[i] != 0)
                        begin
                            r = '{StatusDelivered, ent_id[i], ent_seq[i], ent_len[i], 1'b0};
                            outs.insert(outs.size(), r);
                        end
                        drop = 1'b1;
                        moved = 1'b1;
                    end
                    else if ({1'b0, now} > {17'b0, age_lim}
                             && {1'b0, ent_time[i]} < {1'b0, now} - {17'b0, age_lim})
                        drop = 1'b1;
                end
                if (!drop)
                begin
                    ent_seq[w] = ent_seq[i]; ent_len[w] = ent_len[i];
                    ent_syn[w] = ent_syn[i]; ent_time[w] = ent_time[i];
                    ent_id[w] = ent_id[i];
                    w++;
                end
            end
            for (int i = w; i < n; i++) ent_valid[i] = 1'b0;
        end
        while (moved);
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) pending_q.insert(pending_q.size(), outs[i]);
    endtask

    task automatic send_segment(input logic func, input logic [31:0] seq,
                                input logic [15:0] len, input logic syn,
                                input logic [47:0] arr, input logic [47:0] now,
                                input logic [7:0] id);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {7'b0, id, now, arr, syn, len, seq};
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        reorder_step(func, seq, len, syn, arr, now, id);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() > 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_age_limit(input logic [31:0] v);
        wait_drain();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= RegAgeLimit; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        age_lim = v;
    endtask

    // output side back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(negedge clk)
    begin
        seg_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (m_axis_tuser !== e.status || m_axis_tdata[7:0] !== e.handle
                    || m_axis_tdata[39:8] !== e.seq || m_axis_tdata[55:40] !== e.len
                    || m_axis_tdata[63:56] !== 8'b0 || m_axis_tlast !== e.last)
                begin
                    $display("%0t: mismatch expected st=%b h=%h s=%h l=%h last=%b",
                             $time, e.status, e.handle, e.seq, e.len, e.last);
                    $display("%0t:          actual   st=%b h=%h s=%h l=%h last=%b",
                             $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                             m_axis_tdata[55:40], m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_segment(FuncArrival, 32'h100, 16'd0, 1'b1, 48'd10, 48'd10, 8'h00); // SYN dropped
        send_segment(FuncArrival, 32'h100, 16'd10, 1'b0, 48'd10, 48'd10, 8'hFF);
        send_segment(FuncArrival, 32'h10A, 16'd0, 1'b0, 48'd11, 48'd11, 8'h01); // silent
        send_segment(FuncArrival, 32'h114, 16'd5, 1'b0, 48'd12, 48'd12, 8'h02);
        send_segment(FuncArrival, 32'h10A, 16'd10, 1'b0, 48'd12, 48'd12, 8'h03);
        send_segment(FuncArrival, 32'h200, 16'd1, 1'b0, 48'd13, 48'd40000, 8'h04); // aged
        send_segment(FuncArrival, 32'h300, 16'd1, 1'b0, 48'hFFFF_FFFF_FFFF, 48'd40000, 8'h05);
        // table full: fill with out of order entries
        for (int i = 0; i < 17; i++)
            send_segment(FuncArrival, 32'h1000 + i, 16'd1, 1'b0, 48'd50000, 48'd50000,
                         8'(8'h10 + i));
        send_segment(FuncArrival, 32'h119, 16'hFFFF, 1'b1, 48'd50000, 48'd50000, 8'h30);
        send_segment(FuncRestart, '1, '1, 1'b1, '1, '1, '1);
        // wrap back to unsynchronised
        send_segment(FuncArrival, 32'hFFFF_FFF0, 16'd16, 1'b0, 48'd0, 48'd0, 8'h40);
        send_segment(FuncArrival, 32'hFFFF_FFFF, 16'd1, 1'b0, 48'd0, 48'hFFFF_FFFF_FFFF, 8'h41);
        send_segment(FuncRestart, '0, '0, 1'b0, '0, '0, '0);
    endtask

    task automatic test_age_extremes();
        write_age_limit(32'd1);
        send_segment(FuncArrival, 32'h5, 16'd1, 1'b0, 48'd0, 48'd1, 8'h50);
        send_segment(FuncArrival, 32'h9, 16'd1, 1'b0, 48'd0, 48'd1, 8'h51);
        send_segment(FuncArrival, 32'h7, 16'd1, 1'b0, 48'd0, 48'd2, 8'h52);
        write_age_limit(32'hFFFF_FFFF);
        send_segment(FuncArrival, 32'h20, 16'd1, 1'b0, 48'd0, 48'h1_0000_0000, 8'h53);
        send_segment(FuncArrival, 32'h30, 16'd1, 1'b0, 48'd0, 48'h1_0000_0001, 8'h54);
        send_segment(FuncRestart, '0, '0, 1'b0, '0, '0, '0);
    endtask

    task automatic test_random_streams(input int items);
        logic [31:0] sseq;
        logic [47:0] now;
        logic [31:0] seqs[8];
        logic [15:0] lens[8];
        int order[8];
        int k;
        int t;
        int sent;
        sent = 0;
        now = 48'($urandom);
        sseq = $urandom;
        while (sent < items)
        begin
            if (sent > items / 2 && sent < items / 2 + 8)
            begin
                wait_drain();
                write_age_limit($urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 200));
            end
            now = now + $urandom_range(0, 50);
            case ($urandom_range(0, 9))
                0:
                begin
                    send_segment(FuncRestart, $urandom, 16'($urandom), 1'($urandom),
                                 {16'($urandom), 32'($urandom)}, now, 8'($urandom));
                    sseq = $urandom;
                    send_segment(FuncArrival, sseq - 1, 16'd0, 1'b1, now, now, 8'($urandom));
                    sent += 2;
                end
                1:
                begin
                    send_segment(FuncArrival, $urandom, 16'($urandom), 1'($urandom),
                                 {16'($urandom), 32'($urandom)},
                                 $urandom_range(0, 1) ? {16'($urandom), 32'($urandom)} : now,
                                 8'($urandom));
                    sent++;
                end
                default:
                begin
                    k = $urandom_range(1, 8);
                    for (int i = 0; i < k; i++)
                    begin
                        lens[i] = $urandom_range(0, 7) == 0 ? 16'($urandom) :
                                  16'($urandom_range(0, 1500));
                        seqs[i] = sseq;
                        sseq = sseq + 32'(lens[i]);
                        order[i] = i;
                    end
                    for (int i = k - 1; i > 0; i--)
                    begin
                        int j;
                        j = $urandom_range(0, i);
                        t = order[i]; order[i] = order[j]; order[j] = t;
                    end
                    for (int i = 0; i < k; i++)
                    begin
                        if ($urandom_range(0, 15) != 0)
                            send_segment(FuncArrival, seqs[order[i]], lens[order[i]],
                                         $urandom_range(0, 9) == 0, now - $urandom_range(0, 300),
                                         now, 8'($urandom));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        age_lim = AgeLimitReset;
        next_seq = '0;
        for (int i = 0; i < Depth; i++) ent_valid[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_age_extremes();
        write_age_limit(32'd30000);
        test_random_streams(340);
        wait_drain();
        quiet = 1'b1;
        test_random_streams(60);
        wait_drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
